@@ src/gtcr_pkg.sv @@
package gtcr_pkg;

    localparam int GLYPH_COLS  = 5;
    localparam int CELL_COLS   = 6;
    localparam int CELL_ROWS   = 8;
    localparam int SCREEN_COLS = 128;
    localparam int HALF_COLS   = 64;
    localparam int SCREEN_ROWS = 64;

    localparam int FONT_DEPTH   = 480;
    localparam int FONT_AW      = 9;
    localparam int GLYPH_COUNT  = FONT_DEPTH / GLYPH_COLS;
    localparam int FIRST_CHAR   = 32'h20;
    localparam int GLYPH_OFFSET = (FIRST_CHAR * GLYPH_COUNT - FIRST_CHAR) % GLYPH_COUNT;

    localparam int GLYPH_W = 10;
    localparam int COL_W   = 9;
    localparam int IDX_W   = 4;

    localparam logic [7:0] CMD_PAGE  = 8'hB8;
    localparam logic [7:0] CMD_COL   = 8'h40;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    localparam logic [1:0] FUNC_PRINT  = 2'd0;
    localparam logic [1:0] FUNC_LOAD   = 2'd1;
    localparam logic [1:0] FUNC_CURSOR = 2'd2;

    localparam logic [1:0] CHIP_LEFT  = 2'd1;
    localparam logic [1:0] CHIP_RIGHT = 2'd2;

    localparam logic REG_INVERT = 1'b0;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
        logic [8:0] font_addr;
        logic [7:0] font_byte;
        logic [4:0] cursor_col;
        logic [2:0] cursor_row;
    } item_t;

    typedef struct packed {
        logic [1:0] chip_select;
        logic       is_data;
        logic [7:0] value;
        logic       last;
    } word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_PAGE,
        ST_COL,
        ST_DATA
    } state_t;

    typedef struct packed {
        logic accept_print;
        logic accept_load;
        logic accept_cursor;
        logic reduce_step;
        logic emit_page;
        logic emit_col;
        logic emit_data;
        logic switch_chip;
    } ctrl_cmd_t;

    typedef struct packed {
        logic glyph_ge_count;
        logic can_emit;
        logic at_half;
        logic last_col;
    } dp_status_t;

    function automatic logic [2:0] next_row(input logic [2:0] y);
        logic [2:0] n;
        logic [9:0] r;
        n = y + 3'd1;
        r = 10'(n) * 10'(CELL_ROWS);
        return (r >= 10'(SCREEN_ROWS)) ? 3'd0 : n;
    endfunction

endpackage

@@ src/glcd_text_char_renderer_top.sv @@
// Text renderer for a two-chip, page-addressed 128x64 graphic LCD.
// Input transactions on item_valid/item_ready carry one of three functions:
// print a character, load one font byte, or set the text cursor. A print
// produces a stream of words on word_valid/word_ready: a set-page command,
// a set-column command, five glyph columns and two spacer columns, with a
// further page and column pair whenever output moves to the right chip.
// The final word of each character carries last.
// Load and cursor transactions complete in the cycle they are accepted.
// A print is accepted, its character code is reduced to a glyph index by
// repeated subtraction, then one word per cycle goes out while the
// receiver keeps up, save at the switch to the right chip. The font store
// has a single read port whose address runs one word ahead of the output.
// One character is handled at a time; a stalled receiver holds the output
// register and the sequence waits with it.
// Reset clears the cursor, the invert register and the output valid flag;
// the font store holds no defined contents until it is loaded.
module glcd_text_char_renderer_top
    import gtcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        word_valid,
    input  logic        word_ready,
    output word_t       word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       invert_reg, invert_next;
    ctrl_cmd_t  cmd;
    dp_status_t sts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_INVERT) ? {31'd0, invert_reg} : 32'd0;

    always_comb
    begin
        invert_next = invert_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_INVERT))
        begin
            invert_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg <= 1'b0;
        end
        else
        begin
            invert_reg <= invert_next;
        end
    end

    gtcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .func      (item.func),
        .item_ready(item_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    gtcr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .item      (item),
        .invert    (invert_reg),
        .word_valid(word_valid),
        .word_ready(word_ready),
        .word      (word)
    );

    a_busy_after_print: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.func == FUNC_PRINT) |=> !item_ready)
        else $error("print transaction did not make the block busy");

    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word.last |-> word.is_data)
        else $error("last flag on a command word");

    a_chip_select: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> (word.chip_select == CHIP_LEFT) || (word.chip_select == CHIP_RIGHT))
        else $error("invalid chip select on output word");

    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word_ready |=> word_valid && $stable(word))
        else $error("output word changed while the receiver stalled");

endmodule

@@ src/gtcr_ram.sv @@
module gtcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 480,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wen,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/gtcr_dp.sv @@
module gtcr_dp
    import gtcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  cmd,
    output dp_status_t sts,
    input  item_t      item,
    input  logic       invert,
    output logic       word_valid,
    input  logic       word_ready,
    output word_t      word
);

    logic [4:0]         cursor_x_reg, cursor_x_next;
    logic [2:0]         cursor_y_reg, cursor_y_next;
    logic [GLYPH_W-1:0] glyph_reg, glyph_next;
    logic [FONT_AW-1:0] fa_reg, fa_next;
    logic [1:0]         chip_reg, chip_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   last_reg, last_next;
    logic               out_valid_reg, out_valid_next;
    word_t              out_reg, out_next;

    logic [COL_W:0]     px;
    logic [5:0]         adv_x;
    logic [COL_W:0]     adv_px;
    logic [7:0]         page;
    logic [7:0]         rdata;
    logic [7:0]         fill;
    logic               font_wen;

    assign px       = (COL_W+1)'(cursor_x_reg) * (COL_W+1)'(CELL_COLS);
    assign adv_x    = 6'(cursor_x_reg) + 6'd1;
    assign adv_px   = (COL_W+1)'(adv_x[4:0]) * (COL_W+1)'(CELL_COLS);
    assign page     = 8'((11'(cursor_y_reg) * 11'(CELL_ROWS)) >> 3);
    assign fill     = invert ? BYTE_ONES : 8'h00;
    assign font_wen = cmd.accept_load && ({1'b0, item.font_addr} < 10'(FONT_DEPTH));

    assign sts.glyph_ge_count = glyph_reg >= GLYPH_W'(GLYPH_COUNT);
    assign sts.can_emit       = !out_valid_reg || word_ready;
    assign sts.at_half        = col_reg == COL_W'(HALF_COLS);
    assign sts.last_col       = idx_reg == last_reg;

    gtcr_ram #(
        .WIDTH(8),
        .DEPTH(FONT_DEPTH)
    ) u_font (
        .clk  (clk),
        .wen  (font_wen),
        .waddr(item.font_addr),
        .wdata(item.font_byte),
        .raddr(fa_next),
        .rdata(rdata)
    );

    always_comb
    begin
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        glyph_next     = glyph_reg;
        fa_next        = fa_reg;
        chip_next      = chip_reg;
        col_next       = col_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !word_ready;
        out_next       = out_reg;

        if (cmd.accept_cursor)
        begin
            cursor_x_next = item.cursor_col;
            cursor_y_next = item.cursor_row;
        end

        if (cmd.accept_print)
        begin
            glyph_next = GLYPH_W'(item.char_code) + GLYPH_W'(GLYPH_OFFSET);
            idx_next   = '0;
            last_next  = IDX_W'(CELL_COLS);
            if (px + (COL_W+1)'(GLYPH_COLS) >= (COL_W+1)'(SCREEN_COLS))
            begin
                chip_next     = CHIP_LEFT;
                col_next      = '0;
                cursor_x_next = '0;
                cursor_y_next = next_row(cursor_y_reg);
            end
            else if (px >= (COL_W+1)'(HALF_COLS))
            begin
                chip_next = CHIP_RIGHT;
                col_next  = COL_W'(px - (COL_W+1)'(HALF_COLS));
                if (px + (COL_W+1)'(CELL_COLS) >= (COL_W+1)'(SCREEN_COLS))
                begin
                    last_next = IDX_W'((COL_W+1)'(SCREEN_COLS) - px - (COL_W+1)'(1));
                end
            end
            else
            begin
                chip_next = CHIP_LEFT;
                col_next  = COL_W'(px);
            end
        end

        if (cmd.reduce_step)
        begin
            if (sts.glyph_ge_count)
            begin
                glyph_next = glyph_reg - GLYPH_W'(GLYPH_COUNT);
            end
            else
            begin
                fa_next = FONT_AW'(13'(glyph_reg) * 13'(GLYPH_COLS));
            end
        end

        if (cmd.switch_chip)
        begin
            chip_next = CHIP_RIGHT;
            col_next  = '0;
        end

        if (cmd.emit_page)
        begin
            out_valid_next       = 1'b1;
            out_next.chip_select = chip_reg;
            out_next.is_data     = 1'b0;
            out_next.value       = CMD_PAGE + page;
            out_next.last        = 1'b0;
        end

        if (cmd.emit_col)
        begin
            out_valid_next       = 1'b1;
            out_next.chip_select = chip_reg;
            out_next.is_data     = 1'b0;
            out_next.value       = CMD_COL + 8'(col_reg);
            out_next.last        = 1'b0;
        end

        if (cmd.emit_data)
        begin
            out_valid_next       = 1'b1;
            out_next.chip_select = chip_reg;
            out_next.is_data     = 1'b1;
            out_next.value       = (idx_reg < IDX_W'(GLYPH_COLS)) ? (rdata ^ fill) : fill;
            out_next.last        = sts.last_col;
            idx_next             = idx_reg + IDX_W'(1);
            col_next             = col_reg + COL_W'(1);
            if (idx_reg < IDX_W'(GLYPH_COLS - 1))
            begin
                fa_next = fa_reg + FONT_AW'(1);
            end
            if (sts.last_col)
            begin
                if (adv_px >= (COL_W+1)'(SCREEN_COLS))
                begin
                    cursor_x_next = '0;
                    cursor_y_next = next_row(cursor_y_reg);
                end
                else
                begin
                    cursor_x_next = adv_x[4:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        glyph_reg <= glyph_next;
        fa_reg    <= fa_next;
        chip_reg  <= chip_next;
        col_reg   <= col_next;
        idx_reg   <= idx_next;
        last_reg  <= last_next;
        out_reg   <= out_next;
    end

    assign word_valid = out_valid_reg;
    assign word       = out_reg;

endmodule

@@ src/gtcr_ctrl.sv @@
module gtcr_ctrl
    import gtcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [1:0] func,
    output logic       item_ready,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    case (func)
                        FUNC_PRINT:
                        begin
                            cmd.accept_print = 1'b1;
                            state_next       = ST_REDUCE;
                        end
                        FUNC_LOAD:   cmd.accept_load   = 1'b1;
                        FUNC_CURSOR: cmd.accept_cursor = 1'b1;
                        default:     cmd = '0;
                    endcase
                end
            end
            ST_REDUCE:
            begin
                cmd.reduce_step = 1'b1;
                if (!sts.glyph_ge_count)
                begin
                    state_next = ST_PAGE;
                end
            end
            ST_PAGE:
            begin
                if (sts.can_emit)
                begin
                    cmd.emit_page = 1'b1;
                    state_next    = ST_COL;
                end
            end
            ST_COL:
            begin
                if (sts.can_emit)
                begin
                    cmd.emit_col = 1'b1;
                    state_next   = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (sts.at_half)
                begin
                    cmd.switch_chip = 1'b1;
                    state_next      = ST_PAGE;
                end
                else if (sts.can_emit)
                begin
                    cmd.emit_data = 1'b1;
                    if (sts.last_col)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ bench/tb_glcd_text_char_renderer_top.sv @@
module tb_glcd_text_char_renderer_top;
    import gtcr_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CLK_HALF = 4;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    item_t       item = '0;
    logic        word_valid;
    logic        word_ready = 1'b0;
    word_t       word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [4:0]  text_col;
    logic [2:0]  text_row;
    logic        invert_on;
    logic [7:0]  font_shadow [FONT_DEPTH];
    bit          font_known [FONT_DEPTH];
    word_t       expected_words [$];

    bit          idling_on;
    int          stall_left;
    int          errors;
    int          cycles;
    word_t       want;

    glcd_text_char_renderer_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word       (word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** glcd_text_char_renderer_top: FAILED **");
            $finish;
        end
    end

    // Receiver side: random stalls while idling is enabled.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            word_ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 4) - 1;
            word_ready <= 1'b0;
        end
        else
        begin
            word_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && word_valid && word_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, word);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (word.chip_select !== want.chip_select)
                begin
                    $display("%0t: chip_select expected %0d actual %0d", $time,
                             want.chip_select, word.chip_select);
                    errors++;
                end
                if (word.is_data !== want.is_data)
                begin
                    $display("%0t: is_data expected %0d actual %0d", $time,
                             want.is_data, word.is_data);
                    errors++;
                end
                if (word.value !== want.value)
                begin
                    $display("%0t: value expected %h actual %h", $time,
                             want.value, word.value);
                    errors++;
                end
                if (word.last !== want.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time,
                             want.last, word.last);
                    errors++;
                end
            end
        end
    end

    function automatic int glyph_of(input logic [7:0] code);
        int count;
        count = FONT_DEPTH / GLYPH_COLS;
        return (int'(code) + 32 * count - FIRST_CHAR) % count;
    endfunction

    function automatic bit glyph_loaded(input int glyph);
        bit ok;
        ok = 1'b1;
        for (int i = 0; i < GLYPH_COLS; i++)
        begin
            ok &= font_known[glyph * GLYPH_COLS + i];
        end
        return ok;
    endfunction

    function automatic logic [2:0] row_after(input logic [2:0] row);
        logic [2:0] nxt;
        nxt = row + 3'd1;
        if (int'(nxt) * CELL_ROWS >= SCREEN_ROWS)
        begin
            nxt = 3'd0;
        end
        return nxt;
    endfunction

    function automatic void queue_word(input logic [1:0] chip, input logic data,
                                       input logic [7:0] val, input logic fin);
        word_t w;
        w.chip_select = chip;
        w.is_data = data;
        w.value = val;
        w.last = fin;
        expected_words.push_back(w);
    endfunction

    function automatic void render_char(input logic [7:0] code);
        int glyph;
        int px;
        int span;
        int page;
        logic [1:0] chip;
        logic [7:0] col_byte;
        glyph = glyph_of(code);
        px = int'(text_col) * CELL_COLS;
        span = CELL_COLS;
        if (px + GLYPH_COLS >= SCREEN_COLS)
        begin
            chip = CHIP_LEFT;
            px = 0;
            text_col = '0;
            text_row = row_after(text_row);
        end
        else if (px >= HALF_COLS)
        begin
            if (px + CELL_COLS >= SCREEN_COLS)
            begin
                span = SCREEN_COLS - px - 1;
            end
            chip = CHIP_RIGHT;
            px -= HALF_COLS;
        end
        else
        begin
            chip = CHIP_LEFT;
        end
        page = int'(text_row) * CELL_ROWS / 8;
        queue_word(chip, 1'b0, 8'(int'(CMD_PAGE) + page), 1'b0);
        queue_word(chip, 1'b0, 8'(int'(CMD_COL) + px), 1'b0);
        for (int i = 0; i <= span; i++)
        begin
            if (px == HALF_COLS)
            begin
                px = 0;
                chip = CHIP_RIGHT;
                queue_word(chip, 1'b0, 8'(int'(CMD_PAGE) + page), 1'b0);
                queue_word(chip, 1'b0, CMD_COL, 1'b0);
            end
            if (i < GLYPH_COLS)
            begin
                col_byte = font_shadow[glyph * GLYPH_COLS + i];
                if (invert_on)
                begin
                    col_byte = ~col_byte;
                end
            end
            else
            begin
                col_byte = invert_on ? BYTE_ONES : 8'h00;
            end
            queue_word(chip, 1'b1, col_byte, i == span);
            px++;
        end
        text_col = text_col + 5'd1;
        if (int'(text_col) * CELL_COLS >= SCREEN_COLS)
        begin
            text_col = '0;
            text_row = row_after(text_row);
        end
    endfunction

    function automatic void apply_item(input item_t it);
        case (it.func)
            FUNC_PRINT:
            begin
                render_char(it.char_code);
            end
            FUNC_LOAD:
            begin
                if (int'(it.font_addr) < FONT_DEPTH)
                begin
                    font_shadow[it.font_addr] = it.font_byte;
                    font_known[it.font_addr] = 1'b1;
                end
            end
            FUNC_CURSOR:
            begin
                text_col = it.cursor_col;
                text_row = it.cursor_row;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic item_t random_item(input logic [1:0] func);
        item_t it;
        it.func = func;
        it.char_code = 8'($urandom);
        it.font_addr = 9'($urandom);
        it.font_byte = 8'($urandom);
        it.cursor_col = 5'($urandom);
        it.cursor_row = 3'($urandom);
        return it;
    endfunction

    task automatic send_item(input item_t it);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (!item_ready);
        apply_item(it);
    endtask

    task automatic load_byte(input int addr, input logic [7:0] data);
        item_t it;
        it = random_item(FUNC_LOAD);
        it.font_addr = 9'(addr);
        it.font_byte = data;
        send_item(it);
    endtask

    task automatic load_glyph(input int glyph);
        for (int i = 0; i < GLYPH_COLS; i++)
        begin
            load_byte(glyph * GLYPH_COLS + i, 8'($urandom));
        end
    endtask

    task automatic print_code(input logic [7:0] code);
        item_t it;
        it = random_item(FUNC_PRINT);
        it.char_code = code;
        send_item(it);
    endtask

    task automatic place_cursor(input logic [4:0] col, input logic [2:0] row);
        item_t it;
        it = random_item(FUNC_CURSOR);
        it.cursor_col = col;
        it.cursor_row = row;
        send_item(it);
    endtask

    // Lets every outstanding word arrive and the block settle before the next phase.
    task automatic wait_drained;
        item_valid <= 1'b0;
        while (expected_words.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_invert(input logic v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(REG_INVERT) * 3'd4;
        pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        invert_on = v;
    endtask

    task automatic test_font_load;
        load_byte(0, 8'h00);
        load_byte(1, 8'hFF);
        load_byte(2, 8'h55);
        load_byte(3, 8'hAA);
        load_byte(4, 8'h81);
        load_byte(FONT_DEPTH, 8'hFF);
        load_byte(511, 8'hFF);
        print_code(8'h20);
    endtask

    task automatic test_code_wrap;
        load_glyph(FONT_DEPTH / GLYPH_COLS - 1);
        print_code(8'h7F);
        print_code(8'hDF);
        print_code(8'h1F);
        print_code(8'hE0);
    endtask

    task automatic test_screen_edges;
        place_cursor(5'd10, 3'd2);
        print_code(8'h20);
        place_cursor(5'd20, 3'd7);
        print_code(8'h7F);
        print_code(8'h80);
        place_cursor(5'd31, 3'd7);
        print_code(8'h20);
        send_item(random_item(FUNC_UNUSED));
        print_code(8'hFF - 8'd32);
    endtask

    task automatic test_invert;
        wait_drained();
        write_invert(1'b1);
        print_code(8'h20);
        print_code(8'hDF);
        place_cursor(5'd10, 3'd0);
        print_code(8'h80);
        wait_drained();
        write_invert(1'b0);
    endtask

    // Mostly print items with random character codes, loading a glyph just before it is first needed.
    task automatic test_random_text(input int count);
        int sent;
        int pick;
        item_t it;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                it = random_item(FUNC_PRINT);
                if (!glyph_loaded(glyph_of(it.char_code)))
                begin
                    load_glyph(glyph_of(it.char_code));
                    sent += GLYPH_COLS;
                end
                send_item(it);
            end
            else if (pick < 70)
            begin
                send_item(random_item(FUNC_CURSOR));
            end
            else if (pick < 80)
            begin
                send_item(random_item(FUNC_LOAD));
            end
            else if (pick < 88)
            begin
                load_glyph($urandom_range(0, FONT_DEPTH / GLYPH_COLS - 1));
                sent += GLYPH_COLS - 1;
            end
            else
            begin
                send_item(random_item(FUNC_UNUSED));
            end
            sent++;
        end
    endtask

    initial
    begin
        text_col = '0;
        text_row = '0;
        invert_on = 1'b0;
        for (int i = 0; i < FONT_DEPTH; i++)
        begin
            font_shadow[i] = '0;
            font_known[i] = 1'b0;
        end
        idling_on = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_invert(1'b0);
        test_font_load();
        test_code_wrap();
        test_screen_edges();
        test_invert();
        test_random_text(50);
        wait_drained();
        write_invert(1'b1);
        test_random_text(50);
        wait_drained();
        write_invert(1'b0);
        idling_on = 1'b0;
        test_random_text(30);
        wait_drained();
        if (errors == 0)
        begin
            $display("** glcd_text_char_renderer_top: PASSED **");
        end
        else
        begin
            $display("** glcd_text_char_renderer_top: FAILED **");
        end
        $finish;
    end

endmodule
